@@ src/irbk_pkg.sv @@
// shared types, constants and lookup functions for the ir bi-phase keypad decoder
package irbk_pkg;

    // width of the interval and unit fields, and of the serial divider
    localparam int DIV_W = 24;

    // event kind codes on the result channel
    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_FIRST   = 2'd1;
    localparam logic [1:0] KIND_REPLACE = 2'd2;
    localparam logic [1:0] KIND_COMMIT  = 2'd3;

    // input action codes
    localparam logic ACT_EDGE  = 1'b0;
    localparam logic ACT_FRAME = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;    // capture the edge item and start the divider
        logic div_step;   // one restoring divide step
        logic round_q;    // round the quotient and size the slot run
        logic fill_step;  // write one half-bit slot
        logic frame_out;  // decode the key, update multitap, load result
    } irbk_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_last;   // divider is on its final step
        logic fill_zero;  // no slots left to write
        logic out_busy;   // result register holds an untaken result
    } irbk_sts_t;

    // symbol from a slot pair: 01 gives 1, 10 gives 0, anything else -1
    function automatic logic signed [1:0] symbol_of(input logic a, input logic b);
        logic signed [1:0] s;
        if (!a && b) begin
            s = 2'sd1;
        end else if (a && !b) begin
            s = 2'sd0;
        end else begin
            s = -2'sd1;
        end
        return s;
    endfunction

    // number of letters on a key
    function automatic logic [2:0] set_size(input logic [3:0] k);
        logic [2:0] n;
        case (k)
            4'd7, 4'd9: n = 3'd4;
            4'd0, 4'd1: n = 3'd1;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

    // letter for a key and tap index
    function automatic logic [7:0] letter_of(input logic [3:0] k, input logic [1:0] tap);
        logic [7:0] c;
        case ({k, tap})
            {4'd0, 2'd0}: c = " ";
            {4'd2, 2'd0}: c = "a";
            {4'd2, 2'd1}: c = "b";
            {4'd2, 2'd2}: c = "c";
            {4'd3, 2'd0}: c = "d";
            {4'd3, 2'd1}: c = "e";
            {4'd3, 2'd2}: c = "f";
            {4'd4, 2'd0}: c = "g";
            {4'd4, 2'd1}: c = "h";
            {4'd4, 2'd2}: c = "i";
            {4'd5, 2'd0}: c = "j";
            {4'd5, 2'd1}: c = "k";
            {4'd5, 2'd2}: c = "l";
            {4'd6, 2'd0}: c = "m";
            {4'd6, 2'd1}: c = "n";
            {4'd6, 2'd2}: c = "o";
            {4'd7, 2'd0}: c = "p";
            {4'd7, 2'd1}: c = "q";
            {4'd7, 2'd2}: c = "r";
            {4'd7, 2'd3}: c = "s";
            {4'd8, 2'd0}: c = "t";
            {4'd8, 2'd1}: c = "u";
            {4'd8, 2'd2}: c = "v";
            {4'd9, 2'd0}: c = "w";
            {4'd9, 2'd1}: c = "x";
            {4'd9, 2'd2}: c = "y";
            {4'd9, 2'd3}: c = "z";
            default:      c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ src/irbk_ctrl.sv @@
// sequencing state machine for the ir bi-phase keypad decoder
module irbk_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_action,
    output logic               s_ready,
    input  irbk_pkg::irbk_sts_t sts,
    output irbk_pkg::irbk_cmd_t cmd
);
    import irbk_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_FRAME = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action == ACT_FRAME) begin
                        state_next = ST_FRAME;
                    end else begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_q = 1'b1;
                state_next  = ST_FILL;
            end
            ST_FILL: begin
                if (sts.fill_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.fill_step = 1'b1;
                end
            end
            ST_FRAME: begin
                // wait for the result register to free up
                if (!sts.out_busy) begin
                    cmd.frame_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/irbk_datapath.sv @@
// divider, half-bit slot buffer, key decode, multitap state and result register
module irbk_datapath #(
    parameter int SLOT_COUNT = 84
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  irbk_pkg::irbk_cmd_t          cmd,
    output irbk_pkg::irbk_sts_t          sts,
    input  logic [irbk_pkg::DIV_W-1:0]   unit_ticks,
    input  logic [irbk_pkg::DIV_W-1:0]   s_interval_ticks,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_event_kind,
    output logic signed [4:0]            m_key_value,
    output logic [7:0]                   m_current_letter,
    output logic [7:0]                   m_committed_letter,
    output logic [15:0]                  m_position
);
    import irbk_pkg::*;

    localparam int FW    = $clog2(SLOT_COUNT + 1);
    localparam int IW    = $clog2(SLOT_COUNT);
    localparam int CW    = $clog2(DIV_W);
    localparam int NSYM  = (SLOT_COUNT + 1) / 2;
    localparam int BASE  = 2 * (NSYM - 4);
    localparam logic [FW-1:0] SLOTS_F = FW'(SLOT_COUNT);
    localparam logic [CW-1:0] DIV_LAST = CW'(DIV_W - 1);

    // divider state
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [CW-1:0]    cnt_reg;

    // slot buffer state
    logic [SLOT_COUNT-1:0] slot_reg;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         n_reg;
    logic                  parity_reg;
    logic                  wval_reg;

    // multitap state
    logic [3:0]  prev_key_reg;
    logic        seen_reg;
    logic [1:0]  tap_reg;
    logic [7:0]  letter_reg;
    logic [15:0] done_reg;

    // result register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [4:0]  out_key_reg;
    logic [7:0]  out_cur_reg;
    logic [7:0]  out_com_reg;
    logic [15:0] out_pos_reg;

    // restoring divide step
    logic [DIV_W:0] trial;
    assign trial = {rem_reg, dvd_reg[DIV_W-1]} - {1'b0, div_reg};

    // rounding and run length
    logic             round_up;
    logic [DIV_W:0]   q_rnd;
    logic [FW-1:0]    room;
    logic [FW-1:0]    run_len;
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, div_reg});
    assign q_rnd    = {1'b0, dvd_reg} + {{DIV_W{1'b0}}, round_up};
    assign room     = SLOTS_F - fill_reg;
    assign run_len  = (q_rnd < {{(DIV_W + 1 - FW){1'b0}}, room}) ? q_rnd[FW-1:0] : room;

    // key decode from the last four symbols, slots at or past the fill count read zero
    logic [SLOT_COUNT:0]  slot_ext;
    logic signed [1:0]    sy0, sy1, sy2, sy3;
    logic signed [4:0]    key;
    always_comb begin
        slot_ext = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ext[i] = slot_reg[i] && (fill_reg > FW'(i));
        end
    end
    assign sy0 = symbol_of(slot_ext[BASE],     slot_ext[BASE + 1]);
    assign sy1 = symbol_of(slot_ext[BASE + 2], slot_ext[BASE + 3]);
    assign sy2 = symbol_of(slot_ext[BASE + 4], slot_ext[BASE + 5]);
    assign sy3 = symbol_of(slot_ext[BASE + 6], slot_ext[BASE + 7]);
    assign key = (5'(sy0) <<< 3) + (5'(sy1) <<< 2) + (5'(sy2) <<< 1) + 5'(sy3);

    // multitap update
    logic        key_ok;
    logic [3:0]  k;
    logic [2:0]  tap_inc;
    logic [1:0]  tap_new;
    logic [1:0]  kind_new;
    logic [7:0]  com_new;
    logic [15:0] done_new;
    logic [7:0]  letter_new;
    assign key_ok = (key == 5'sd0) || ((key >= 5'sd2) && (key <= 5'sd9));
    assign k       = key[3:0];
    assign tap_inc = {1'b0, tap_reg} + 3'd1;

    always_comb begin
        tap_new  = tap_reg;
        kind_new = KIND_INVALID;
        com_new  = 8'h00;
        done_new = done_reg;
        if (key_ok) begin
            if (!seen_reg) begin
                kind_new = KIND_FIRST;
                tap_new  = 2'd0;
            end else if (k == prev_key_reg) begin
                kind_new = KIND_REPLACE;
                tap_new  = (tap_inc >= set_size(k)) ? 2'd0 : tap_inc[1:0];
            end else begin
                kind_new = KIND_COMMIT;
                com_new  = letter_reg;
                done_new = done_reg + 16'd1;
                tap_new  = 2'd0;
            end
        end
    end
    assign letter_new = key_ok ? letter_of(k, tap_new) : letter_reg;

    // divider registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load_in) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            dvd_reg <= s_interval_ticks;
            rem_reg <= '0;
            div_reg <= (unit_ticks == '0) ? DIV_W'(1) : unit_ticks;
        end else if (cmd.div_step) begin
            if (!trial[DIV_W]) begin
                rem_reg <= trial[DIV_W-1:0];
                dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DIV_W-2:0], dvd_reg[DIV_W-1]};
                dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // slot buffer, one slot written per fill step
    always_ff @(posedge aclk) begin
        if (cmd.fill_step) begin
            slot_reg[fill_reg[IW-1:0]] <= wval_reg;
        end
    end

    // fill count, run length and edge parity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            n_reg      <= '0;
            parity_reg <= 1'b0;
            wval_reg   <= 1'b0;
        end else if (cmd.frame_out) begin
            fill_reg   <= '0;
            n_reg      <= '0;
            parity_reg <= 1'b0;
        end else if (cmd.round_q) begin
            n_reg      <= run_len;
            wval_reg   <= parity_reg;
            parity_reg <= ~parity_reg;
        end else if (cmd.fill_step) begin
            fill_reg <= fill_reg + FW'(1);
            n_reg    <= n_reg - FW'(1);
        end
    end

    // multitap state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg <= '0;
            seen_reg     <= 1'b0;
            tap_reg      <= '0;
            letter_reg   <= '0;
            done_reg     <= '0;
        end else if (cmd.frame_out && key_ok) begin
            prev_key_reg <= k;
            seen_reg     <= 1'b1;
            tap_reg      <= tap_new;
            letter_reg   <= letter_new;
            done_reg     <= done_new;
        end
    end

    // result register, held until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.frame_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.frame_out) begin
            out_kind_reg <= kind_new;
            out_key_reg  <= key;
            out_cur_reg  <= letter_new;
            out_com_reg  <= com_new;
            out_pos_reg  <= done_new;
        end
    end

    // status back to the controller
    assign sts.div_last  = (cnt_reg == DIV_LAST);
    assign sts.fill_zero = (n_reg == '0);
    assign sts.out_busy  = out_valid_reg && !m_ready;

    assign m_valid            = out_valid_reg;
    assign m_event_kind       = out_kind_reg;
    assign m_key_value        = out_key_reg;
    assign m_current_letter   = out_cur_reg;
    assign m_committed_letter = out_com_reg;
    assign m_position         = out_pos_reg;

endmodule

@@ src/ir_biphase_keypad_multitap.sv @@
// top level of the ir bi-phase remote decoder with multitap letter entry
//
// Input channel (s_): one transfer per IR event. action 0 carries the tick
// interval since the previous edge; action 1 marks the end of a frame.
// Result channel (m_): one transfer per frame end with event kind, decoded
// key value, current and committed letter, and committed letter count.
// Edge items give no result.
// Config: APB register 0 at address 0, unit_ticks (24 bit, reset 22550).
// Processing: an edge item passes through the bit-serial restoring divider
// (one quotient bit per cycle), then writes n half-bit slots, one slot per
// cycle, where n is at most SLOT_COUNT.
// A frame end waits in the frame state while the output register holds an
// untaken result; its result is then loaded into the output register.
// Reset empties the slot buffer (fill count to zero) and clears the
// multitap state and the result valid flag.
// A stalled result stays in the output register; edge items keep being
// taken meanwhile, and a frame end waits only until that result is taken.
module ir_biphase_keypad_multitap #(
    parameter int SLOT_COUNT = 84
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_action,
    input  logic [irbk_pkg::DIV_W-1:0] s_interval_ticks,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_event_kind,
    output logic signed [4:0]          m_key_value,
    output logic [7:0]                 m_current_letter,
    output logic [7:0]                 m_committed_letter,
    output logic [15:0]                m_position,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import irbk_pkg::*;

    localparam logic [DIV_W-1:0] UNIT_RESET = DIV_W'(22550);
    localparam logic             ADDR_UNIT  = 1'b0;

    logic [DIV_W-1:0] unit_reg;
    irbk_cmd_t        cmd;
    irbk_sts_t        sts;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= UNIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_UNIT)) begin
            unit_reg <= pwdata[DIV_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_UNIT) ? {{(32 - DIV_W){1'b0}}, unit_reg} : 32'h0;

    irbk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    irbk_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .unit_ticks         (unit_reg),
        .s_interval_ticks   (s_interval_ticks),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_key_value        (m_key_value),
        .m_current_letter   (m_current_letter),
        .m_committed_letter (m_committed_letter),
        .m_position         (m_position)
    );

endmodule

@@ tb/tb_ir_biphase_keypad_multitap.sv @@
// self-checking testbench for the ir bi-phase keypad multitap decoder
`timescale 1ns / 1ps

module tb_ir_biphase_keypad_multitap;
    import irbk_pkg::*;

    localparam int          SLOTS           = 84;
    localparam int          KEY_SLOTS       = 8;
    localparam logic [2:0]  UNIT_TICKS_ADDR = 3'd0;
    localparam logic [23:0] UNIT_RESET      = 24'd22550;
    localparam logic [23:0] TICKS_MAX       = 24'hFFFFFF;
    localparam int          SETTLE_CYCLES   = 200;
    localparam int          LONG_HOLD       = 3000;
    localparam int          RANDOM_ITEMS    = 1820;
    localparam int          NUM_PHASES      = 6;
    localparam longint      CYCLE_LIMIT     = 2000000;

    typedef struct packed {
        logic        action;
        logic [23:0] ticks;
    } ir_event_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  key;
        logic [7:0]  current;
        logic [7:0]  committed;
        logic [15:0] position;
    } keypad_event_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #1 aclk = ~aclk;

    // dut ports
    logic               s_valid          = 1'b0;
    logic               s_ready;
    logic               s_action         = 1'b0;
    logic [23:0]        s_interval_ticks = '0;
    logic               m_valid;
    logic               m_ready          = 1'b0;
    logic [1:0]         m_event_kind;
    logic signed [4:0]  m_key_value;
    logic [7:0]         m_current_letter;
    logic [7:0]         m_committed_letter;
    logic [15:0]        m_position;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [2:0]         paddr            = '0;
    logic [31:0]        pwdata           = '0;
    logic [31:0]        prdata;
    logic               pready;

    ir_biphase_keypad_multitap #(
        .SLOT_COUNT(SLOTS)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_interval_ticks   (s_interval_ticks),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_kind       (m_event_kind),
        .m_key_value        (m_key_value),
        .m_current_letter   (m_current_letter),
        .m_committed_letter (m_committed_letter),
        .m_position         (m_position),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // decoder state mirrored on the testbench side
    logic [23:0] unit_now = UNIT_RESET;
    logic        slot_bits [SLOTS];
    int unsigned fill_level;
    logic        run_parity;
    int          last_key;
    bit          key_known;
    int unsigned tap_now;
    logic [7:0]  letter_held;
    logic [15:0] letters_committed;

    ir_event_t     ir_events_q [$];
    keypad_event_t expected_keypad_events [$];
    logic          slot_plan [$];

    int     errors        = 0;
    int     items_queued  = 0;
    int     items_in      = 0;
    int     results_out   = 0;
    int     kind_count [4] = '{0, 0, 0, 0};
    int     gen_prev_key  = -1;
    longint cycle_count   = 0;

    // ---------------------------------------------------------------
    // decoder prediction
    // ---------------------------------------------------------------

    task automatic clear_slots();
        foreach (slot_bits[i]) slot_bits[i] = 1'b0;
        fill_level = 0;
        run_parity = 1'b0;
    endtask

    task automatic reset_decoder_state();
        clear_slots();
        unit_now          = UNIT_RESET;
        last_key          = 0;
        key_known         = 1'b0;
        tap_now           = 0;
        letter_held       = 8'h00;
        letters_committed = 16'h0000;
    endtask

    // unwritten slots read low
    function automatic int slot_value(int unsigned idx);
        if (idx < SLOTS && idx < fill_level) begin
            return int'(slot_bits[idx]);
        end
        return 0;
    endfunction

    function automatic int symbol_value(int unsigned k);
        int a;
        int b;
        a = slot_value(2 * k);
        b = slot_value(2 * k + 1);
        if (a == 0 && b == 1) begin
            return 1;
        end
        if (a == 1 && b == 0) begin
            return 0;
        end
        return -1;
    endfunction

    function automatic int unsigned taps_on_key(int k);
        if (k == 7 || k == 9) begin
            return 4;
        end
        if (k == 0) begin
            return 1;
        end
        return 3;
    endfunction

    // letters run on from 'a', keys 7 and 9 carry a fourth one
    function automatic logic [7:0] key_letter(int k, int unsigned tap);
        int code;
        if (k == 0) begin
            return " ";
        end
        code = "a" + 3 * (k - 2) + ((k > 7) ? 1 : 0) + tap;
        return code[7:0];
    endfunction

    task automatic decode_ir_item(input logic act, input logic [23:0] ticks);
        int unsigned   u;
        int unsigned   q;
        int unsigned   r;
        int unsigned   room;
        int unsigned   n;
        int unsigned   nsym;
        int unsigned   i;
        int            key;
        keypad_event_t res;
        if (act == ACT_EDGE) begin
            // round to half-bit units, append a run at the current parity
            u = (unit_now == 0) ? 1 : unit_now;
            q = ticks / u;
            r = ticks % u;
            if (2 * r >= u) q++;
            room = SLOTS - fill_level;
            n = (q < room) ? q : room;
            for (i = 0; i < n; i++) slot_bits[fill_level + i] = run_parity;
            fill_level += n;
            run_parity = ~run_parity;
        end else begin
            // last four symbols weighted 8 4 2 1
            nsym = (SLOTS + 1) / 2;
            key = 0;
            for (i = 0; i < 4; i++) key = 2 * key + symbol_value(nsym - 4 + i);
            res.kind      = KIND_INVALID;
            res.committed = 8'h00;
            if (key == 0 || (key >= 2 && key <= 9)) begin
                if (!key_known) begin
                    res.kind = KIND_FIRST;
                    tap_now = 0;
                end else if (key == last_key) begin
                    res.kind = KIND_REPLACE;
                    tap_now++;
                    if (tap_now >= taps_on_key(key)) tap_now = 0;
                end else begin
                    res.kind = KIND_COMMIT;
                    res.committed = letter_held;
                    letters_committed++;
                    tap_now = 0;
                end
                key_known   = 1'b1;
                last_key    = key;
                letter_held = key_letter(key, tap_now);
            end
            res.key      = key[4:0];
            res.current  = letter_held;
            res.position = letters_committed;
            expected_keypad_events.push_back(res);
            clear_slots();
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus generation
    // ---------------------------------------------------------------

    task automatic push_ir_event(input logic act, input logic [23:0] ticks);
        ir_event_t ev;
        ev.action = act;
        ev.ticks  = ticks;
        ir_events_q.push_back(ev);
        items_queued++;
    endtask

    // interval that rounds to q units, often right on a rounding boundary
    function automatic logic [23:0] ticks_for_run(int unsigned q);
        longint unsigned u;
        longint unsigned lo;
        longint unsigned hi;
        int              pick;
        u  = (unit_now == 0) ? 1 : unit_now;
        hi = q * u + (u - 1) / 2;
        lo = (q == 0) ? 0 : q * u - u / 2;
        if (lo > TICKS_MAX) begin
            return TICKS_MAX;
        end
        if (hi > TICKS_MAX) hi = TICKS_MAX;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            return lo[23:0];
        end
        if (pick == 1) begin
            return hi[23:0];
        end
        return 24'($urandom_range(int'(hi), int'(lo)));
    endfunction

    // turn the planned slot pattern into edge intervals and a frame end
    task automatic queue_plan_as_frame();
        logic        level;
        int unsigned run;
        int          i;
        level = 1'b0;
        run   = 0;
        for (i = 0; i < slot_plan.size(); i++) begin
            if (slot_plan[i] != level) begin
                push_ir_event(ACT_EDGE, ticks_for_run(run));
                level = ~level;
                run   = 0;
            end
            run++;
        end
        if (run != 0) push_ir_event(ACT_EDGE, ticks_for_run(run));
        push_ir_event(ACT_FRAME, 24'($urandom_range(0, TICKS_MAX)));
        slot_plan.delete();
    endtask

    task automatic plan_random_bits(input int unsigned count, input int unsigned max_run);
        logic        v;
        int unsigned len;
        while (count != 0) begin
            v   = 1'($urandom_range(0, 1));
            len = $urandom_range(1, max_run);
            if (len > count) len = count;
            repeat (len) slot_plan.push_back(v);
            count -= len;
        end
    endtask

    // symbol 1 is low then high, symbol 0 is high then low
    task automatic plan_key_symbols(input int key);
        int i;
        for (i = 3; i >= 0; i--) begin
            if (key[i]) begin
                slot_plan.push_back(1'b0);
                slot_plan.push_back(1'b1);
            end else begin
                slot_plan.push_back(1'b1);
                slot_plan.push_back(1'b0);
            end
        end
    endtask

    function automatic int pick_valid_key();
        int key;
        if (gen_prev_key >= 0 && $urandom_range(0, 1) == 1) begin
            return gen_prev_key;
        end
        key = $urandom_range(1, 9);
        if (key == 1) key = 0;
        return key;
    endfunction

    task automatic queue_plain_key_frame(input int key);
        repeat (SLOTS - KEY_SLOTS) slot_plan.push_back(1'b0);
        plan_key_symbols(key);
        queue_plan_as_frame();
        gen_prev_key = key;
    endtask

    task automatic queue_random_frame();
        int pick;
        int key;
        int n;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            // well-formed frame with a usable key
            key = pick_valid_key();
            gen_prev_key = key;
            plan_random_bits(SLOTS - KEY_SLOTS, 30);
            plan_key_symbols(key);
            queue_plan_as_frame();
        end else if (pick < 70) begin
            // well-formed frame, key outside the keypad set
            key = $urandom_range(9, 15);
            if (key == 9) key = 1;
            plan_random_bits(SLOTS - KEY_SLOTS, 30);
            plan_key_symbols(key);
            queue_plan_as_frame();
        end else if (pick < 80) begin
            // damaged symbols in the key area
            plan_random_bits(SLOTS, 3);
            queue_plan_as_frame();
        end else if (pick < 88) begin
            // short frame, tail reads low
            plan_random_bits($urandom_range(0, SLOTS - 1), 30);
            queue_plan_as_frame();
        end else if (pick < 94) begin
            // overlong frame, extra slots dropped
            key = pick_valid_key();
            gen_prev_key = key;
            plan_random_bits(SLOTS - KEY_SLOTS, 30);
            plan_key_symbols(key);
            plan_random_bits($urandom_range(1, 20), 6);
            queue_plan_as_frame();
        end else begin
            // raw noise over the whole interval range
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++) push_ir_event(ACT_EDGE, 24'($urandom_range(0, TICKS_MAX)));
            push_ir_event(ACT_FRAME, 24'($urandom_range(0, TICKS_MAX)));
        end
    endtask

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_unit_readback();
        logic [31:0] rd;
        apb_read(UNIT_TICKS_ADDR, rd);
        if (rd[23:0] !== unit_now) begin
            $error("unit_ticks readback: expected %0d, got %0d", unit_now, rd[23:0]);
            errors++;
        end
    endtask

    task automatic wait_until_drained();
        while (ir_events_q.size() != 0 || s_valid || expected_keypad_events.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // ---------------------------------------------------------------
    // input driver: bursts with random gaps
    // ---------------------------------------------------------------

    ir_event_t next_event;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_ir_item(s_action, s_interval_ticks);
                items_in++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (ir_events_q.size() != 0) begin
                    next_event = ir_events_q.pop_front();
                    s_valid          <= 1'b1;
                    s_action         <= next_event.action;
                    s_interval_ticks <= next_event.ticks;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result receiver: stall modes plus one long hold-off on request
    // ---------------------------------------------------------------

    bit rx_hold_flip = 1'b0;
    bit rx_hold_seen = 1'b0;
    int rx_hold_left = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_hold_left <= 0;
            rx_mode_left <= 0;
        end else if (rx_hold_flip != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_flip;
            rx_hold_left <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready      <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(20, 300);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    keypad_event_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_keypad_events.size() == 0) begin
                $error("result transfer with no frame end pending: key %0d", m_key_value);
                errors++;
            end else begin
                want = expected_keypad_events.pop_front();
                results_out++;
                kind_count[want.kind]++;
                if (m_event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, m_event_kind);
                    errors++;
                end
                if (m_key_value !== want.key) begin
                    $error("key_value: expected %0d, got %0d", $signed(want.key), m_key_value);
                    errors++;
                end
                if (m_current_letter !== want.current) begin
                    $error("current_letter: expected %0d, got %0d", want.current,
                           m_current_letter);
                    errors++;
                end
                if (m_committed_letter !== want.committed) begin
                    $error("committed_letter: expected %0d, got %0d", want.committed,
                           m_committed_letter);
                    errors++;
                end
                if (m_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, m_position);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_keypad_events.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------

    initial begin
        int          phase;
        int          target;
        logic [23:0] unit_pick;
        reset_decoder_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            // unit setting for this phase, block is idle here
            if (phase != 0) begin
                case (phase)
                    1:       unit_pick = 24'd1;
                    2:       unit_pick = TICKS_MAX;
                    3:       unit_pick = 24'($urandom_range(2, 1000));
                    4:       unit_pick = 24'($urandom_range(1001, TICKS_MAX - 1));
                    default: unit_pick = UNIT_RESET;
                endcase
                apb_write(UNIT_TICKS_ADDR, {8'h00, unit_pick});
                unit_now = unit_pick;
            end
            check_unit_readback();
            @(negedge aclk);

            // hold the result side off while the sender keeps going
            if (phase == 3) rx_hold_flip = ~rx_hold_flip;

            if (phase == 0) begin
                // frame end with nothing captured
                push_ir_event(ACT_FRAME, TICKS_MAX);
                // half-unit boundary, zero and full-scale intervals, buffer overflow
                push_ir_event(ACT_EDGE, UNIT_RESET / 2);
                push_ir_event(ACT_EDGE, UNIT_RESET / 2 - 1);
                push_ir_event(ACT_EDGE, 24'd0);
                push_ir_event(ACT_EDGE, TICKS_MAX);
                push_ir_event(ACT_FRAME, 24'd0);
                // first key, same key again, then a different key commits
                queue_plain_key_frame(2);
                queue_plain_key_frame(2);
                queue_plain_key_frame(9);
            end

            target = items_queued + RANDOM_ITEMS / NUM_PHASES;
            while (items_queued < target) queue_random_frame();

            // sender waits for every result before the next setting
            wait_until_drained();
            repeat (SETTLE_CYCLES) @(negedge aclk);
        end

        $display("covered %0d input transfers and %0d keypad results over %0d unit settings",
                 items_in, results_out, NUM_PHASES);
        $display("event kinds: invalid %0d, first %0d, replace %0d, commit %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
